// ===== src/thbc_pkg.sv =====
// Shared constants for the NTC thermistor beta-equation converter.
// No dependencies; used by the converter top level and its port checker.
`timescale 1ns / 1ps

package thbc_pkg;

   localparam int ADC_BITS_DEF   = 10;
   localparam int FRAC_BITS      = 30;
   localparam int REG_W          = 36;
   localparam int CSR_IDX_W      = 8;
   localparam int DIV_W          = 47;
   localparam int ABS_ZERO_CENTI = 27315;

   // clock edges from request transfer to response transfer
   // (the strobe rises on the edge before)
   localparam int LATENCY = FRAC_BITS + DIV_W + 7;

   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   localparam logic [REG_W-1:0] INV_BETA_RST = 36'd278357374;
   localparam logic [REG_W-1:0] INV_REF_RST  = 36'd3687780070;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_BETA = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_REF  = 8'd1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_SAT  = 2'd3;

endpackage

// ===== src/thermistor_beta_to_celsius_unit.sv =====
// Converts an NTC divider ADC reading to hundredths of a degree Celsius.
// Depends on thbc_pkg (constants, status and register codes).
`timescale 1ns / 1ps
//
//  channel  | ports                                        | transfer when
//  request  | start, busy, req_raw_reading                 | start && !busy
//  response | rsp_valid, rsp_temp_centi_c, rsp_status     | rsp_valid (one cycle)
//  csr      | csr_valid, csr_ready, csr_index, csr_wdata   | csr_valid && csr_ready
//
// One reading per cycle outside reset; the strobe rises once a reading has passed
// through every stage, and the response transfers at the next edge.
// The pipeline holds 30 squaring stages per log2 and a 47-stage bit-per-cycle divider.
// busy is high only during reset; reset clears every stage valid and loads both CSRs with defaults.
// The response side cannot stall, so the pipeline always advances.

module thermistor_beta_to_celsius_unit #(
   parameter int ADC_BITS = thbc_pkg::ADC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ADC_BITS-1:0]                 req_raw_reading,
   output logic                                rsp_valid,
   output logic signed [15:0]                  rsp_temp_centi_c,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [thbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [thbc_pkg::REG_W-1:0]          csr_wdata
);
   import thbc_pkg::*;

   localparam int KW  = $clog2(ADC_BITS);
   localparam int LW  = KW + FRAC_BITS;
   localparam int HW  = LW - 15;
   localparam int SW  = REG_W + LW + 1;
   localparam int TW  = SW - FRAC_BITS;
   localparam int IW  = TW + 2;
   localparam int MW  = TW + 1;
   localparam int RW  = MW + 1;
   localparam int NW  = DIV_W;
   localparam int KCW = NW + 2;

   localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};
   localparam logic [NW-1:0] NUM_KELVIN = NW'(100) << 40;
   localparam logic signed [KCW-1:0] SAT_HI = KCW'(32767);
   localparam logic signed [KCW-1:0] SAT_LO = -KCW'(32768);

   typedef struct packed {
      logic       vld;
      logic [1:0] spec;
      logic       neg;
      logic       zero;
   } tag_type;

   // ---------------- configuration ----------------
   logic [REG_W-1:0] inv_beta_ff, inv_ref_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_beta_ff <= INV_BETA_RST;
         inv_ref_ff  <= INV_REF_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_INV_BETA) begin
            inv_beta_ff <= csr_wdata;
         end else if (csr_index == CSR_INV_REF) begin
            inv_ref_ff <= csr_wdata;
         end
      end
   end

   // ---------------- stage 0: normalize ----------------
   logic [ADC_BITS-1:0] xa, xb;
   logic [KW-1:0]       ka, kb;
   logic [31:0]         ma_in, mb_in;
   tag_type             t0_in;

   always_comb begin
      xa = FULL_SCALE - req_raw_reading;
      xb = req_raw_reading;
      ka = '0;
      kb = '0;
      for (int i = 0; i < ADC_BITS; i++) begin
         if (xa[i]) ka = KW'(i);
         if (xb[i]) kb = KW'(i);
      end
      ma_in = {{(32-ADC_BITS){1'b0}}, xa} << (5'd31 - 5'(ka));
      mb_in = {{(32-ADC_BITS){1'b0}}, xb} << (5'd31 - 5'(kb));
      t0_in.vld  = start && !busy;
      t0_in.neg  = 1'b0;
      t0_in.zero = 1'b0;
      if (req_raw_reading == '0)           t0_in.spec = ST_ZERO;
      else if (req_raw_reading == FULL_SCALE) t0_in.spec = ST_FULL;
      else                                 t0_in.spec = ST_OK;
   end

   logic [31:0]   ma_ff [0:FRAC_BITS];
   logic [31:0]   mb_ff [0:FRAC_BITS];
   logic [LW-1:0] la_ff [0:FRAC_BITS];
   logic [LW-1:0] lb_ff [0:FRAC_BITS];
   tag_type       tq_ff [0:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) tq_ff[0] <= '0;
      else       tq_ff[0] <= t0_in;
   end

   always_ff @(posedge clock) begin
      ma_ff[0] <= ma_in;
      mb_ff[0] <= mb_in;
      la_ff[0] <= {ka, {FRAC_BITS{1'b0}}};
      lb_ff[0] <= {kb, {FRAC_BITS{1'b0}}};
   end

   // ---------------- log2 fraction: one squaring per stage ----------------
   for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_sq
      logic [63:0] sqa, sqb;
      logic [32:0] ta, tb;

      assign sqa = 64'(ma_ff[j-1]) * 64'(ma_ff[j-1]);
      assign sqb = 64'(mb_ff[j-1]) * 64'(mb_ff[j-1]);
      assign ta  = sqa[63:31];
      assign tb  = sqb[63:31];

      always_ff @(posedge clock) begin
         if (reset) tq_ff[j] <= '0;
         else       tq_ff[j] <= tq_ff[j-1];
      end

      always_ff @(posedge clock) begin
         ma_ff[j] <= ta[32] ? ta[32:1] : ta[31:0];
         mb_ff[j] <= tb[32] ? tb[32:1] : tb[31:0];
         la_ff[j] <= la_ff[j-1] | (LW'(ta[32]) << (FRAC_BITS - j));
         lb_ff[j] <= lb_ff[j-1] | (LW'(tb[32]) << (FRAC_BITS - j));
      end
   end

   // ---------------- difference of logs ----------------
   logic [LW-1:0] dmag_in, dmag_ff;
   tag_type       td_in, td_ff;

   always_comb begin
      td_in     = tq_ff[FRAC_BITS];
      td_in.neg = la_ff[FRAC_BITS] < lb_ff[FRAC_BITS];
      dmag_in   = td_in.neg ? lb_ff[FRAC_BITS] - la_ff[FRAC_BITS]
                            : la_ff[FRAC_BITS] - lb_ff[FRAC_BITS];
   end

   // ---------------- natural log: times ln 2, rounded ----------------
   logic [63:0]   lnprod;
   logic [LW-1:0] ln_in, ln_ff;
   tag_type       tl_ff;

   assign lnprod = 64'(dmag_ff) * 64'(LN2_Q30) + (64'd1 << (FRAC_BITS - 1));
   assign ln_in  = LW'(lnprod >> FRAC_BITS);

   // ---------------- inv_beta * ln, split in two partial products ----------------
   logic [REG_W+HW-1:0] phi_in, phi_ff;
   logic [REG_W+14:0]   plo_in, plo_ff;
   tag_type             tm1_ff;

   assign phi_in = (REG_W+HW)'(inv_beta_ff) * (REG_W+HW)'(ln_ff[LW-1:15]);
   assign plo_in = (REG_W+15)'(inv_beta_ff) * (REG_W+15)'(ln_ff[14:0]);

   logic [SW-1:0] psum;
   logic [TW-1:0] term_in, term_ff;
   tag_type       tm2_ff;

   assign psum    = (SW'(phi_ff) << 15) + SW'(plo_ff) + (SW'(1) << (FRAC_BITS - 1));
   assign term_in = psum[SW-1:FRAC_BITS];

   // ---------------- 1/T and divider setup ----------------
   logic signed [IW-1:0] invt;
   logic [MW-1:0]        mag_t;
   tag_type              tt_in;

   always_comb begin
      invt     = tm2_ff.neg ? $signed(IW'(inv_ref_ff)) - $signed(IW'(term_ff))
                            : $signed(IW'(inv_ref_ff)) + $signed(IW'(term_ff));
      mag_t    = invt[IW-1] ? MW'(-invt) : MW'(invt);
      tt_in      = tm2_ff;
      tt_in.neg  = invt[IW-1];
      tt_in.zero = (invt == '0);
   end

   logic [NW-1:0] n_ff   [0:NW];
   logic [MW-1:0] dv_ff  [0:NW];
   logic [RW-1:0] rem_ff [0:NW];
   logic [NW-1:0] q_ff   [0:NW];
   tag_type       tv_ff  [0:NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         td_ff    <= '0;
         tl_ff    <= '0;
         tm1_ff   <= '0;
         tm2_ff   <= '0;
         tv_ff[0] <= '0;
      end else begin
         td_ff    <= td_in;
         tl_ff    <= td_ff;
         tm1_ff   <= tl_ff;
         tm2_ff   <= tm1_ff;
         tv_ff[0] <= tt_in;
      end
   end

   always_ff @(posedge clock) begin
      dmag_ff   <= dmag_in;
      ln_ff     <= ln_in;
      phi_ff    <= phi_in;
      plo_ff    <= plo_in;
      term_ff   <= term_in;
      n_ff[0]   <= NUM_KELVIN + NW'(mag_t >> 1);
      dv_ff[0]  <= mag_t;
      rem_ff[0] <= '0;
      q_ff[0]   <= '0;
   end

   // ---------------- restoring divider: one quotient bit per stage ----------------
   for (genvar j = 1; j <= NW; j++) begin : g_div
      logic [RW-1:0] cand;
      logic          ge;

      assign cand = {rem_ff[j-1][RW-2:0], n_ff[j-1][NW-j]};
      assign ge   = cand >= {1'b0, dv_ff[j-1]};

      always_ff @(posedge clock) begin
         if (reset) tv_ff[j] <= '0;
         else       tv_ff[j] <= tv_ff[j-1];
      end

      always_ff @(posedge clock) begin
         n_ff[j]   <= n_ff[j-1];
         dv_ff[j]  <= dv_ff[j-1];
         rem_ff[j] <= ge ? cand - {1'b0, dv_ff[j-1]} : cand;
         q_ff[j]   <= {q_ff[j-1][NW-2:0], ge};
      end
   end

   // ---------------- offset, saturate, special cases ----------------
   logic signed [KCW-1:0] qx, temp;
   logic signed [15:0]    temp_in;
   logic [1:0]            status_in;
   tag_type               tf;

   always_comb begin
      tf   = tv_ff[NW];
      qx   = $signed({2'b00, q_ff[NW]});
      temp = (tf.neg ? -qx : qx) - KCW'(ABS_ZERO_CENTI);
      if (tf.spec != ST_OK) begin
         temp_in   = 16'(-ABS_ZERO_CENTI);
         status_in = tf.spec;
      end else if (tf.zero || temp > SAT_HI) begin
         temp_in   = 16'sd32767;
         status_in = ST_SAT;
      end else if (temp < SAT_LO) begin
         temp_in   = -16'sd32768;
         status_in = ST_SAT;
      end else begin
         temp_in   = temp[15:0];
         status_in = ST_OK;
      end
   end

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_temp_ff;
   logic [1:0]         rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= tf.vld;
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff   <= temp_in;
      rsp_status_ff <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temp_centi_c = rsp_temp_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== src/thbc_port_checker.sv =====
// Port-level checks for the thermistor converter, bound to its top level.
// Depends on thbc_pkg (latency, status codes).
`timescale 1ns / 1ps

module thbc_port_checker #(
   parameter int ADC_BITS = thbc_pkg::ADC_BITS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [ADC_BITS-1:0]         req_raw_reading,
   input logic                        rsp_valid,
   input logic signed [15:0]          rsp_temp_centi_c,
   input logic [1:0]                  rsp_status
);
   import thbc_pkg::*;

   // every response traces back to a request transfer, found with $past at LATENCY
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without matching request transfer");

   a_zero_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ZERO |->
         $past(req_raw_reading, LATENCY) == '0 && rsp_temp_centi_c == -16'sd27315)
      else $error("zero-reading status inconsistent");

   a_full_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         $past(req_raw_reading, LATENCY) == {ADC_BITS{1'b1}})
      else $error("full-scale status without full-scale reading");

   a_sat_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SAT |->
         rsp_temp_centi_c == 16'sd32767 || rsp_temp_centi_c == -16'sd32768)
      else $error("saturated status with in-range temperature");

endmodule

bind thermistor_beta_to_celsius_unit thbc_port_checker #(.ADC_BITS(ADC_BITS)) u_thbc_port_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_raw_reading  (req_raw_reading),
   .rsp_valid        (rsp_valid),
   .rsp_temp_centi_c (rsp_temp_centi_c),
   .rsp_status       (rsp_status)
);
